### rtl/box_smooth_threshold_classifier_defines.svh
// Assertion macros shared by the box smoothing classifier RTL.
`ifndef BOX_SMOOTH_THRESHOLD_CLASSIFIER_DEFINES_SVH
`define BOX_SMOOTH_THRESHOLD_CLASSIFIER_DEFINES_SVH

`define BSTC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define BSTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bstc_pkg.sv
// Types and constants shared by the box smoothing classifier modules.
package bstc_pkg;

  localparam int SAMPLE_W       = 8;
  localparam int COORD_W        = 8;
  localparam int DIM_W          = 9;
  localparam int GAIN_W         = 12;
  localparam int LEVEL_W        = 8;
  localparam int COL_W          = 10;
  localparam int SUM_W          = 12;
  localparam int PROD_W         = SUM_W + GAIN_W;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 12;
  localparam int NUM_CELLS      = 2;

  localparam int QIN_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int QPROD_W     = QIN_W + RECIP_W;
  localparam int RECIP9      = 7282;
  localparam int RECIP_SHIFT = 16;
  localparam int SAT_LIMIT   = 9 << LEVEL_W;

  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 9'd256;
  localparam logic [GAIN_W-1:0]   GAIN_RST         = 12'd256;
  localparam logic [LEVEL_W-1:0]  WATER_RST        = 8'd85;
  localparam logic [LEVEL_W-1:0]  PLAIN_RST        = 8'd170;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_SMOOTHING_GAIN = 3'd2,
    REG_WATER_LEVEL    = 3'd3,
    REG_PLAIN_LEVEL    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLASS_WATER = 2'd0,
    CLASS_PLAIN = 2'd1,
    CLASS_HILL  = 2'd2
  } terrain_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] two;
    logic [SAMPLE_W-1:0] one;
  } lb_word_t;

  typedef struct packed {
    logic [COL_W-1:0] a;
    logic [COL_W-1:0] b;
  } col_sum_t;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } win_sum_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [SUM_W-1:0]   sum;
    logic               last;
  } emit_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LEVEL_W-1:0] level;
    terrain_e           cls;
    logic               last;
  } result_t;

endpackage

### rtl/bstc_line_buf.sv
// Line buffer memory holding the two rows above the current one, with write forwarding.
module bstc_line_buf #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output bstc_pkg::lb_word_t rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  bstc_pkg::lb_word_t wdata_i
);
  import bstc_pkg::*;

  lb_word_t mem [DEPTH];
  lb_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bstc_col_cell.sv
// One window column cell: holds a column sum pair and adds it into the passing window sums.
module bstc_col_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               clear_i,
  input  bstc_pkg::col_sum_t col_i,
  input  bstc_pkg::win_sum_t acc_i,
  output bstc_pkg::col_sum_t col_o,
  output bstc_pkg::win_sum_t acc_o
);
  import bstc_pkg::*;

  col_sum_t col_q;
  col_sum_t col_d;

  always_comb begin
    col_d = col_q;
    if (shift_i) begin
      col_d = clear_i ? '0 : col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o   = col_q;
  assign acc_o.a = acc_i.a + SUM_W'(col_q.a);
  assign acc_o.b = acc_i.b + SUM_W'(col_q.b);

endmodule

### rtl/bstc_level_unit.sv
// Scales window sums by gain, divides by 9, saturates, classifies; one per beat unless stalled.
module bstc_level_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bstc_pkg::GAIN_W-1:0]  gain_i,
  input  logic [bstc_pkg::LEVEL_W-1:0] water_i,
  input  logic [bstc_pkg::LEVEL_W-1:0] plain_i,
  input  logic                         res_valid_i,
  output logic                         res_ready_o,
  input  bstc_pkg::emit_t              res_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bstc_pkg::result_t            out_o
);
  import bstc_pkg::*;

  logic               m_valid_q;
  logic [COORD_W-1:0] m_row_q;
  logic [COORD_W-1:0] m_col_q;
  logic               m_last_q;
  logic [PROD_W-1:0]  m_prod_q;

  logic               o_valid_q;
  result_t            o_res_q;

  logic               o_ready;
  logic [PROD_W-1:0]  scaled;
  logic               sat;
  logic [QPROD_W-1:0] quot_prod;
  logic [LEVEL_W-1:0] level;
  terrain_e           cls;

  assign o_ready     = !o_valid_q || out_ready_i;
  assign res_ready_o = !m_valid_q || o_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (res_ready_o) begin
        m_valid_q <= res_valid_i;
      end
      if (o_ready) begin
        o_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      m_row_q  <= res_i.row;
      m_col_q  <= res_i.col;
      m_last_q <= res_i.last;
      m_prod_q <= PROD_W'(res_i.sum) * PROD_W'(gain_i);
    end
  end

  assign scaled    = m_prod_q >> GAIN_FRAC_BITS;
  assign sat       = scaled >= PROD_W'(SAT_LIMIT);
  assign quot_prod = QPROD_W'(scaled[QIN_W-1:0]) * QPROD_W'(RECIP9);
  assign level     = sat ? '1 : quot_prod[RECIP_SHIFT +: LEVEL_W];

  always_comb begin
    priority if (level <= water_i) begin
      cls = CLASS_WATER;
    end else if (level <= plain_i) begin
      cls = CLASS_PLAIN;
    end else begin
      cls = CLASS_HILL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_valid_q && o_ready) begin
      o_res_q.row   <= m_row_q;
      o_res_q.col   <= m_col_q;
      o_res_q.level <= level;
      o_res_q.cls   <= cls;
      o_res_q.last  <= m_last_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_o       = o_res_q;

endmodule

### rtl/box_smooth_threshold_classifier.sv
// Top level of the 3x3 box smoothing filter with water, plain and hill classification.
// Each result passes the window stage and the level unit's product and output registers.
// One sample is accepted per cycle while each yields at most one result and the output is not
// stalled; a sample that completes k windows (two at a row end or on the last row, four at the
// frame end) stays until the level unit, one result per cycle when not stalled, takes all k.
// Reset clears the counters, column cells and pipeline, and loads the register defaults.
`include "box_smooth_threshold_classifier_defines.svh"
module box_smooth_threshold_classifier #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bstc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bstc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bstc_pkg::SAMPLE_W-1:0]   height_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bstc_pkg::COORD_W-1:0]    out_row_o,
  output logic [bstc_pkg::COORD_W-1:0]    out_col_o,
  output logic [bstc_pkg::LEVEL_W-1:0]    smoothed_level_o,
  output logic [1:0]                      terrain_class_o,
  output logic                            last_of_run_o
);
  import bstc_pkg::*;

  localparam int LB_DEPTH = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int LB_AW    = $clog2(LB_DEPTH);

  localparam int EMIT_UL   = 0;
  localparam int EMIT_UP   = 1;
  localparam int EMIT_LEFT = 2;
  localparam int EMIT_HERE = 3;

  logic [DIM_W-1:0]   frame_width_q;
  logic [DIM_W-1:0]   frame_height_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [LEVEL_W-1:0] water_level_q;
  logic [LEVEL_W-1:0] plain_level_q;

  logic [COORD_W-1:0] row_q, row_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [DIM_W-1:0]   width_m1;
  logic [DIM_W-1:0]   height_m1;
  logic               row_end;
  logic               last_row;
  logic [3:0]         mask_new;
  logic               in_fire;

  logic                s1_valid_q;
  logic [3:0]          s1_mask_q;
  logic                s1_row_end_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [COORD_W-1:0]  s1_row_q;
  logic [COORD_W-1:0]  s1_col_q;

  lb_word_t            lb_rd;
  lb_word_t            lb_wr;
  logic [SAMPLE_W-1:0] above_one;
  logic [SAMPLE_W-1:0] above_two;
  col_sum_t            col_chain [NUM_CELLS+1];
  win_sum_t            acc_chain [NUM_CELLS+1];

  logic    [3:0] pick;
  logic    [3:0] mask_left;
  logic    [3:0] mask_after;
  emit_t         emit;
  logic          emit_valid;
  logic          emit_ready;
  logic          emit_fire;
  logic          s1_retire;
  result_t       res_out;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      gain_q         <= GAIN_RST;
      water_level_q  <= WATER_RST;
      plain_level_q  <= PLAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:    frame_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height_q <= cfg_data_i[DIM_W-1:0];
        REG_SMOOTHING_GAIN: gain_q         <= cfg_data_i[GAIN_W-1:0];
        REG_WATER_LEVEL:    water_level_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_PLAIN_LEVEL:    plain_level_q  <= cfg_data_i[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective frame size and the position of the incoming sample.
  always_comb begin
    priority if (frame_width_q == '0) begin
      width_m1 = '0;
    end else if (frame_width_q > DIM_W'(LB_DEPTH)) begin
      width_m1 = DIM_W'(LB_DEPTH - 1);
    end else begin
      width_m1 = frame_width_q - 1'b1;
    end
    priority if (frame_height_q == '0) begin
      height_m1 = '0;
    end else if (frame_height_q > FRAME_HEIGHT_RST) begin
      height_m1 = FRAME_HEIGHT_RST - 1'b1;
    end else begin
      height_m1 = frame_height_q - 1'b1;
    end
  end

  assign row_end  = {1'b0, col_q} >= width_m1;
  assign last_row = {1'b0, row_q} >= height_m1;

  assign mask_new[EMIT_UL]   = (row_q != '0) && (col_q != '0);
  assign mask_new[EMIT_UP]   = (row_q != '0) && row_end;
  assign mask_new[EMIT_LEFT] = last_row && (col_q != '0);
  assign mask_new[EMIT_HERE] = last_row && row_end;

  assign in_ready_o = !s1_valid_q || s1_retire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_fire) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Window stage: holds one sample until all of its results have left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_mask_q  <= '0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      s1_mask_q  <= mask_new;
    end else if (s1_retire) begin
      s1_valid_q <= 1'b0;
      s1_mask_q  <= '0;
    end else begin
      s1_mask_q  <= mask_after;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_end_q <= row_end;
      s1_sample_q  <= height_sample_i;
      s1_row_q     <= row_q;
      s1_col_q     <= col_q;
    end
  end

  assign lb_wr.two = lb_rd.one;
  assign lb_wr.one = s1_sample_q;

  bstc_line_buf #(
    .DEPTH (LB_DEPTH),
    .AW    (LB_AW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .re_i    (in_fire),
    .raddr_i (col_q[LB_AW-1:0]),
    .rdata_o (lb_rd),
    .we_i    (s1_retire),
    .waddr_i (s1_col_q[LB_AW-1:0]),
    .wdata_i (lb_wr)
  );

  assign above_one = (s1_row_q != '0) ? lb_rd.one : '0;
  assign above_two = (s1_row_q > COORD_W'(1)) ? lb_rd.two : '0;

  assign col_chain[0].a = COL_W'(above_two) + COL_W'(above_one) + COL_W'(s1_sample_q);
  assign col_chain[0].b = COL_W'(above_one) + COL_W'(s1_sample_q);
  assign acc_chain[0].a = SUM_W'(col_chain[0].a);
  assign acc_chain[0].b = SUM_W'(col_chain[0].b);

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cells
    bstc_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_retire),
      .clear_i (s1_row_end_q),
      .col_i   (col_chain[i]),
      .acc_i   (acc_chain[i]),
      .col_o   (col_chain[i+1]),
      .acc_o   (acc_chain[i+1])
    );
  end

  // Results go out in window order: upper-left, upper, left, here.
  always_comb begin
    pick     = '0;
    emit.row = s1_row_q;
    emit.col = s1_col_q;
    emit.sum = acc_chain[1].b;
    priority if (s1_mask_q[EMIT_UL]) begin
      pick[EMIT_UL] = 1'b1;
      emit.row      = s1_row_q - 1'b1;
      emit.col      = s1_col_q - 1'b1;
      emit.sum      = acc_chain[2].a;
    end else if (s1_mask_q[EMIT_UP]) begin
      pick[EMIT_UP] = 1'b1;
      emit.row      = s1_row_q - 1'b1;
      emit.sum      = acc_chain[1].a;
    end else if (s1_mask_q[EMIT_LEFT]) begin
      pick[EMIT_LEFT] = 1'b1;
      emit.col        = s1_col_q - 1'b1;
      emit.sum        = acc_chain[2].b;
    end else begin
      pick[EMIT_HERE] = s1_mask_q[EMIT_HERE];
    end
    emit.last = ((s1_mask_q & ~pick) == '0);
  end

  assign mask_left  = s1_mask_q & ~pick;
  assign emit_valid = s1_valid_q && (s1_mask_q != '0);
  assign emit_fire  = emit_valid && emit_ready;
  assign mask_after = emit_fire ? mask_left : s1_mask_q;
  assign s1_retire  = s1_valid_q && (mask_after == '0);

  bstc_level_unit u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .water_i     (water_level_q),
    .plain_i     (plain_level_q),
    .res_valid_i (emit_valid),
    .res_ready_o (emit_ready),
    .res_i       (emit),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res_out)
  );

  assign out_row_o        = res_out.row;
  assign out_col_o        = res_out.col;
  assign smoothed_level_o = res_out.level;
  assign terrain_class_o  = res_out.cls;
  assign last_of_run_o    = res_out.last;

  `BSTC_ASSERT_IMPLIES(a_empty_no_pending, !s1_valid_q, s1_mask_q == '0, "pending results in empty stage")
  `BSTC_ASSERT_NEXT(a_mask_only_shrinks, s1_valid_q && !in_fire, (s1_mask_q & ~$past(s1_mask_q)) == '0, "pending results grew")
  `BSTC_ASSERT_IMPLIES(a_done_frees_stage, s1_valid_q && s1_mask_q == '0, in_ready_o, "finished sample still blocks input")
  `BSTC_ASSERT_NEXT(a_row_end_wraps, in_fire && row_end, col_q == '0, "column count did not wrap at row end")

endmodule
